[rtl/alt_pkg.sv]
// Shared types, constants and the arctangent table of the tilt-angle block.
`default_nettype none

package alt_pkg;

  // Field and datapath widths.
  localparam int unsigned AXIS_W      = 16;
  localparam int unsigned ROLL_W      = 16;
  localparam int unsigned PITCH_W     = 15;
  localparam int unsigned FILT_W      = 32;
  localparam int unsigned FILT_FRAC   = 15;
  localparam int unsigned KEEP_W      = 33;
  localparam int unsigned WEIGHT_W    = 16;
  localparam int unsigned MUL_W       = 32;
  localparam int unsigned PROD_W      = 64;
  localparam int unsigned SQ_W        = 64;
  localparam int unsigned ROOT_W      = 32;
  localparam int unsigned CIN_W       = 34;
  localparam int unsigned CXY_W       = 36;
  localparam int unsigned Z_W         = 32;
  localparam int unsigned ZFRAC       = 20;
  localparam int unsigned ATAN_LEN    = 24;
  localparam int unsigned ATAN_IDX_W  = $clog2(ATAN_LEN);
  localparam int unsigned ATAN_W      = 27;

  // Vector normalization: grow the larger component to at least 2^NORM_TOP.
  localparam int unsigned NORM_TOP    = 30;
  localparam int unsigned NORM_COARSE = 8;

  // Filter weight in Q15: one, and the value after reset.
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 16'd32768;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd16384;

  // 180 degrees with ZFRAC fraction bits.
  localparam logic signed [Z_W-1:0] HALF_TURN = 32'sd188743680;

  localparam int unsigned ROLL_LIM_DEG  = 180;
  localparam int unsigned PITCH_LIM_DEG = 90;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_ROLL_GO,
    ST_ROLL_WAIT,
    ST_PITCH_GO,
    ST_PITCH_WAIT,
    ST_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    CP_IDLE,
    CP_NORM,
    CP_ITER,
    CP_DONE
  } cordic_phase_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // atan(2^-i) in degrees with ZFRAC fraction bits.
  function automatic logic [ATAN_W-1:0] atan_deg_q20(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 27'd47185920;
      5'd1:    v = 27'd27855475;
      5'd2:    v = 27'd14718068;
      5'd3:    v = 27'd7471121;
      5'd4:    v = 27'd3750058;
      5'd5:    v = 27'd1876857;
      5'd6:    v = 27'd938658;
      5'd7:    v = 27'd469357;
      5'd8:    v = 27'd234682;
      5'd9:    v = 27'd117342;
      5'd10:   v = 27'd58671;
      5'd11:   v = 27'd29335;
      5'd12:   v = 27'd14668;
      5'd13:   v = 27'd7334;
      5'd14:   v = 27'd3667;
      5'd15:   v = 27'd1833;
      5'd16:   v = 27'd917;
      5'd17:   v = 27'd458;
      5'd18:   v = 27'd229;
      5'd19:   v = 27'd115;
      5'd20:   v = 27'd57;
      5'd21:   v = 27'd29;
      5'd22:   v = 27'd14;
      5'd23:   v = 27'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/alt_chan_if.sv]
// Valid/ready channel interfaces for the sample input and the angle result.
`default_nettype none

interface alt_in_if
  import alt_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [AXIS_W-1:0] accel_x;
  logic signed [AXIS_W-1:0] accel_y;
  logic signed [AXIS_W-1:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                  output ready);
endinterface

interface alt_out_if
  import alt_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [ROLL_W-1:0]  roll_angle;
  logic signed [PITCH_W-1:0] pitch_angle;
  logic signed [AXIS_W-1:0]  smooth_x;
  logic signed [AXIS_W-1:0]  smooth_y;
  logic signed [AXIS_W-1:0]  smooth_z;

  modport source (output valid, output roll_angle, output pitch_angle,
                  output smooth_x, output smooth_y, output smooth_z, input ready);
  modport sink   (input valid, input roll_angle, input pitch_angle,
                  input smooth_x, input smooth_y, input smooth_z, output ready);
endinterface

`default_nettype wire

[rtl/alt_mul.sv]
// Shared signed multiplier with a registered product.
`default_nettype none

module alt_mul
  import alt_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic signed [MUL_W-1:0]  op_a,
  input  wire logic signed [MUL_W-1:0]  op_b,
  output logic signed [PROD_W-1:0]      prod
);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(op_a) * PROD_W'(op_b);
  end

endmodule

`default_nettype wire

[rtl/alt_isqrt.sv]
// Iterative integer square root, one result bit per cycle.
`default_nettype none

module alt_isqrt
  import alt_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [SQ_W-1:0] value,
  output logic [ROOT_W-1:0]    root,
  output unit_stat_t           stat
);

  localparam int unsigned REM_W = ROOT_W + 3;
  localparam int unsigned CNT_W = $clog2(ROOT_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_W - 1);

  logic [SQ_W-1:0]   rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;

  always_comb begin
    rem_sh = {rem_r[REM_W-3:0], rad_r[SQ_W-1 -: 2]};
    trial  = REM_W'({root_r, 2'b01});
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rad_r  <= value;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[SQ_W-3:0], 2'b00};
      if (fits) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign root      = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

[rtl/alt_cordic.sv]
// Iterative CORDIC vectoring unit giving atan2 in degrees.
`default_nettype none

module alt_cordic
  import alt_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
)
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [CIN_W-1:0] y_in,
  input  wire logic signed [CIN_W-1:0] x_in,
  output logic signed [Z_W-1:0]        z_out,
  output unit_stat_t                   stat
);

  localparam logic [ATAN_IDX_W-1:0] STEP_LAST = ATAN_IDX_W'(CORDIC_STEPS - 1);
  localparam logic [CXY_W-1:0] NORM_FINE_LIM   = CXY_W'(1) << NORM_TOP;
  localparam logic [CXY_W-1:0] NORM_COARSE_LIM = CXY_W'(1) << (NORM_TOP - NORM_COARSE);

  cordic_phase_t phase_r, phase_nxt;

  logic signed [CXY_W-1:0] x_r;
  logic signed [CXY_W-1:0] y_r;
  logic signed [Z_W-1:0]   z_r;
  logic [ATAN_IDX_W-1:0]   i_r;

  logic signed [CXY_W-1:0] x_ext;
  logic signed [CXY_W-1:0] y_ext;
  logic [CXY_W-1:0]        abs_x;
  logic [CXY_W-1:0]        abs_y;
  logic [CXY_W-1:0]        mag_max;
  logic signed [CXY_W-1:0] dx;
  logic signed [CXY_W-1:0] dy;
  logic signed [Z_W-1:0]   step_ang;
  logic                    is_zero;

  always_comb begin
    x_ext    = CXY_W'(x_in);
    y_ext    = CXY_W'(y_in);
    is_zero  = (x_in == '0) && (y_in == '0);
    abs_x    = x_r[CXY_W-1] ? CXY_W'(-x_r) : CXY_W'(x_r);
    abs_y    = y_r[CXY_W-1] ? CXY_W'(-y_r) : CXY_W'(y_r);
    mag_max  = (abs_x > abs_y) ? abs_x : abs_y;
    dx       = y_r >>> i_r;
    dy       = x_r >>> i_r;
    step_ang = Z_W'(atan_deg_q20(i_r));
  end

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      CP_IDLE: begin
        if (start) begin
          phase_nxt = is_zero ? CP_DONE : CP_NORM;
        end
      end
      CP_NORM: begin
        if (mag_max >= NORM_FINE_LIM) begin
          phase_nxt = CP_ITER;
        end
      end
      CP_ITER: begin
        if (i_r == STEP_LAST) begin
          phase_nxt = CP_DONE;
        end
      end
      CP_DONE: phase_nxt = CP_IDLE;
      default: phase_nxt = CP_IDLE;
    endcase
  end

  // Status toward the sequencer.
  always_comb begin
    stat.busy = (phase_r != CP_IDLE);
    stat.done = (phase_r == CP_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= CP_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (phase_r)
      CP_IDLE: begin
        i_r <= '0;
        if (start) begin
          if (is_zero) begin
            z_r <= '0;
          end else if (x_in[CIN_W-1]) begin
            // Left half plane: rotate by half a turn first.
            z_r <= y_in[CIN_W-1] ? -HALF_TURN : HALF_TURN;
            x_r <= -x_ext;
            y_r <= -y_ext;
          end else begin
            z_r <= '0;
            x_r <= x_ext;
            y_r <= y_ext;
          end
        end
      end
      CP_NORM: begin
        if (mag_max < NORM_COARSE_LIM) begin
          x_r <= x_r <<< NORM_COARSE;
          y_r <= y_r <<< NORM_COARSE;
        end else if (mag_max < NORM_FINE_LIM) begin
          x_r <= x_r <<< 1;
          y_r <= y_r <<< 1;
        end
      end
      CP_ITER: begin
        if (y_r > 0) begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + step_ang;
        end else begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - step_ang;
        end
        i_r <= i_r + 1'b1;
      end
      default: ;
    endcase
  end

  assign z_out = z_r;

endmodule

`default_nettype wire

[rtl/accel_lowpass_tilt.sv]
// Top level: smoothed three-axis accelerometer to roll and pitch angles.
//
//   Channel   Direction  Handshake            Payload
//   in_ch     sink       valid / ready        accel_x, accel_y, accel_z
//   out_ch    source     valid / ready        roll_angle, pitch_angle, smooth_x/y/z
//   cfg_*     sink       cfg_wr_en (no wait)  cfg_wr_data = smoothing weight, Q15
//
// A sample passes from acceptance to the output register through 9 multiply steps, the square
// root, and per CORDIC pass a start, normalizing, CORDIC_STEPS iterations and a finishing
// phase (a pass on a zero vector skips normalizing and the iterations).
// in_ch.ready is high only while the sequencer is idle between samples. A result that still waits
// in the output register holds the sequencer at the end of the next sample.
// Synchronous reset (rst_n low) clears the filters and sets the weight to one half.
`default_nettype none

module accel_lowpass_tilt
  import alt_pkg::*;
#(
  parameter int unsigned ANGLE_FRAC_BITS = 7,
  parameter int unsigned CORDIC_STEPS    = 16
)
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  alt_in_if.sink                   in_ch,
  alt_out_if.source                out_ch,
  input  wire logic                cfg_wr_en,
  input  wire logic [WEIGHT_W-1:0] cfg_wr_data
);

  // Steps of the multiply phase. The operands for a step are issued in that
  // step, and its product is consumed in the step after.
  localparam logic [3:0] MS_X_KEEP = 4'd0;
  localparam logic [3:0] MS_X_NEW  = 4'd1;
  localparam logic [3:0] MS_Y_KEEP = 4'd2;
  localparam logic [3:0] MS_Y_NEW  = 4'd3;
  localparam logic [3:0] MS_Z_KEEP = 4'd4;
  localparam logic [3:0] MS_Z_NEW  = 4'd5;
  localparam logic [3:0] MS_Y_SQ   = 4'd6;
  localparam logic [3:0] MS_Z_SQ   = 4'd7;
  localparam logic [3:0] MS_LAST   = 4'd8;

  localparam logic signed [PROD_W-1:0] KEEP_ROUND = PROD_W'(2 ** (FILT_FRAC - 1));

  // Angle rounding from ZFRAC to ANGLE_FRAC_BITS fraction bits, then clamping.
  localparam int unsigned ANG_SHIFT = ZFRAC - ANGLE_FRAC_BITS;
  localparam logic signed [Z_W-1:0] ANG_HALF  = Z_W'(2 ** (ANG_SHIFT - 1));
  localparam logic signed [Z_W-1:0] ROLL_LIM  = Z_W'(ROLL_LIM_DEG * (2 ** ANGLE_FRAC_BITS));
  localparam logic signed [Z_W-1:0] PITCH_LIM = Z_W'(PITCH_LIM_DEG * (2 ** ANGLE_FRAC_BITS));

  function automatic logic signed [Z_W-1:0] angle_fit(input logic signed [Z_W-1:0] z,
                                                       input logic signed [Z_W-1:0] lim);
    logic signed [Z_W-1:0] r;
    r = (z + ANG_HALF) >>> ANG_SHIFT;
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  seq_state_t state_r, state_nxt;

  logic [3:0]                mstep_r;
  logic [WEIGHT_W-1:0]       weight_r;
  logic [WEIGHT_W-1:0]       weight_eff_r;
  logic signed [AXIS_W-1:0]  samp_r [3];
  logic signed [FILT_W-1:0]  filt_r [3];
  logic signed [KEEP_W-1:0]  keep_r;
  logic [SQ_W-1:0]           sq_r;
  logic signed [ROLL_W-1:0]  roll_r;
  logic signed [PITCH_W-1:0] pitch_r;
  logic                      out_valid_r;
  logic signed [ROLL_W-1:0]  out_roll_r;
  logic signed [PITCH_W-1:0] out_pitch_r;
  logic signed [AXIS_W-1:0]  out_sx_r;
  logic signed [AXIS_W-1:0]  out_sy_r;
  logic signed [AXIS_W-1:0]  out_sz_r;

  // Sequencer outputs.
  logic in_ready;
  logic mul_active;
  logic sqrt_start;
  logic cordic_start;
  logic load_out;

  // Shared multiplier.
  logic [WEIGHT_W-1:0]       comp_w;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_keep;
  logic signed [FILT_W-1:0]  filt_new;

  // Root and angle units.
  logic [ROOT_W-1:0]         root;
  unit_stat_t                sqrt_stat;
  unit_stat_t                cordic_stat;
  logic signed [CIN_W-1:0]   cordic_y;
  logic signed [CIN_W-1:0]   cordic_x;
  logic signed [Z_W-1:0]     cordic_z;
  logic signed [Z_W-1:0]     ang_fit;

  // ---------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mstep_r == MS_LAST) begin
          state_nxt = ST_SQRT_GO;
        end
      end
      ST_SQRT_GO:   state_nxt = ST_SQRT_WAIT;
      ST_SQRT_WAIT: begin
        if (sqrt_stat.done) begin
          state_nxt = ST_ROLL_GO;
        end
      end
      ST_ROLL_GO:   state_nxt = ST_ROLL_WAIT;
      ST_ROLL_WAIT: begin
        if (cordic_stat.done) begin
          state_nxt = ST_PITCH_GO;
        end
      end
      ST_PITCH_GO:  state_nxt = ST_PITCH_WAIT;
      ST_PITCH_WAIT: begin
        if (cordic_stat.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state_r == ST_IDLE);
    mul_active   = (state_r == ST_MUL);
    sqrt_start   = (state_r == ST_SQRT_GO);
    cordic_start = (state_r == ST_ROLL_GO) || (state_r == ST_PITCH_GO);
    load_out     = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  end

  // ---------------------------------------------------------------------
  // Filter update and squared magnitude on the shared multiplier.
  // f_new = a*w + round((f*(1-w)) / 2^15), which equals the full Q15 update
  // because a*w*2^15 carries no fraction bits.
  // ---------------------------------------------------------------------
  assign comp_w = WEIGHT_ONE - weight_eff_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (mstep_r)
      MS_X_KEEP: begin
        mul_a = filt_r[0];
        mul_b = MUL_W'(comp_w);
      end
      MS_X_NEW: begin
        mul_a = MUL_W'(samp_r[0]);
        mul_b = MUL_W'(weight_eff_r);
      end
      MS_Y_KEEP: begin
        mul_a = filt_r[1];
        mul_b = MUL_W'(comp_w);
      end
      MS_Y_NEW: begin
        mul_a = MUL_W'(samp_r[1]);
        mul_b = MUL_W'(weight_eff_r);
      end
      MS_Z_KEEP: begin
        mul_a = filt_r[2];
        mul_b = MUL_W'(comp_w);
      end
      MS_Z_NEW: begin
        mul_a = MUL_W'(samp_r[2]);
        mul_b = MUL_W'(weight_eff_r);
      end
      MS_Y_SQ: begin
        mul_a = filt_r[1];
        mul_b = filt_r[1];
      end
      MS_Z_SQ: begin
        mul_a = filt_r[2];
        mul_b = filt_r[2];
      end
      default: ;
    endcase
  end

  alt_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  assign prod_keep = (prod + KEEP_ROUND) >>> FILT_FRAC;
  assign filt_new  = FILT_W'(prod + PROD_W'(keep_r));

  // ---------------------------------------------------------------------
  // Square root of fy^2 + fz^2 and the two angle passes.
  // ---------------------------------------------------------------------
  alt_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .value (sq_r),
    .root  (root),
    .stat  (sqrt_stat)
  );

  // Roll is atan2(-fy, fz); pitch is atan2(fx, |(fy, fz)|).
  always_comb begin
    if (state_r == ST_PITCH_GO) begin
      cordic_y = CIN_W'(filt_r[0]);
      cordic_x = signed'({{(CIN_W - ROOT_W){1'b0}}, root});
    end else begin
      cordic_y = -CIN_W'(filt_r[1]);
      cordic_x = CIN_W'(filt_r[2]);
    end
  end

  alt_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .y_in  (cordic_y),
    .x_in  (cordic_x),
    .z_out (cordic_z),
    .stat  (cordic_stat)
  );

  assign ang_fit = angle_fit(cordic_z, (state_r == ST_ROLL_WAIT) ? ROLL_LIM : PITCH_LIM);

  // ---------------------------------------------------------------------
  // Control registers, the filter state and the weight register.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mstep_r     <= '0;
      weight_r    <= WEIGHT_RESET;
      out_valid_r <= 1'b0;
      filt_r[0]   <= '0;
      filt_r[1]   <= '0;
      filt_r[2]   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        weight_r <= cfg_wr_data;
      end
      if (in_ready && in_ch.valid) begin
        mstep_r <= '0;
      end else if (mul_active) begin
        mstep_r <= mstep_r + 1'b1;
      end
      if (mul_active) begin
        case (mstep_r)
          MS_Y_KEEP: filt_r[0] <= filt_new;
          MS_Z_KEEP: filt_r[1] <= filt_new;
          MS_Y_SQ:   filt_r[2] <= filt_new;
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Payload registers.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      samp_r[0]    <= in_ch.accel_x;
      samp_r[1]    <= in_ch.accel_y;
      samp_r[2]    <= in_ch.accel_z;
      // A weight above one acts as one.
      weight_eff_r <= (weight_r > WEIGHT_ONE) ? WEIGHT_ONE : weight_r;
    end
    if (mul_active) begin
      case (mstep_r)
        MS_X_NEW, MS_Y_NEW, MS_Z_NEW: keep_r <= prod_keep[KEEP_W-1:0];
        MS_Z_SQ:                      sq_r   <= SQ_W'(prod);
        MS_LAST:                      sq_r   <= sq_r + SQ_W'(prod);
        default: ;
      endcase
    end
    if (state_r == ST_ROLL_WAIT && cordic_stat.done) begin
      roll_r <= ang_fit[ROLL_W-1:0];
    end
    if (state_r == ST_PITCH_WAIT && cordic_stat.done) begin
      pitch_r <= ang_fit[PITCH_W-1:0];
    end
    if (load_out) begin
      out_roll_r  <= roll_r;
      out_pitch_r <= pitch_r;
      out_sx_r    <= filt_r[0][FILT_FRAC +: AXIS_W];
      out_sy_r    <= filt_r[1][FILT_FRAC +: AXIS_W];
      out_sz_r    <= filt_r[2][FILT_FRAC +: AXIS_W];
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.roll_angle  = out_roll_r;
  assign out_ch.pitch_angle = out_pitch_r;
  assign out_ch.smooth_x    = out_sx_r;
  assign out_ch.smooth_y    = out_sy_r;
  assign out_ch.smooth_z    = out_sz_r;

`ifndef SYNTHESIS
  // The angle unit is never restarted while it still works on a vector.
  assert property (@(posedge clk) disable iff (!rst_n)
    cordic_start |-> !cordic_stat.busy)
    else $error("CORDIC started while busy");

  // The root finishes only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_stat.done |-> (state_r == ST_SQRT_WAIT))
    else $error("square root finished outside its wait state");

  // Leaving the final state always presents a result.
  assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (out_ch.valid && state_r == ST_IDLE))
    else $error("result not presented after completion");

  // The weight in use never exceeds one while a sample is worked on.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (weight_eff_r <= WEIGHT_ONE))
    else $error("effective filter weight above one");
`endif

endmodule

`default_nettype wire
